// ----- sv/ubt_pkg.sv -----
// ----------------------------------------------------------------------------
// ubt_pkg
// Shared types and constants of the UART byte transmitter: frame phases,
// item kinds, register indexes and the item and result records.
// ----------------------------------------------------------------------------
`default_nettype none

package ubt_pkg;

  localparam int DATA_BITS = 8;
  localparam int PERIOD_W  = 16;
  localparam int TICK_W    = PERIOD_W + 1;
  localparam int PHASE_W   = 4;
  localparam int CFG_IDX_W = 2;

  typedef logic [PHASE_W-1:0] phase_t;

  localparam phase_t PH_IDLE   = phase_t'(0);
  localparam phase_t PH_START  = phase_t'(1);
  localparam phase_t PH_PARITY = phase_t'(DATA_BITS + 2);
  localparam phase_t PH_STOP   = phase_t'(DATA_BITS + 3);

  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_SEND = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_BIT_PERIOD  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_INVERT_LINE = CFG_IDX_W'(1);

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
    logic       parity_enable;
    logic       two_stop_bits;
  } item_t;

  typedef struct packed {
    logic tx_line;
    logic busy_res;
    logic accepted;
  } result_t;

endpackage

`default_nettype wire

// ----- sv/ubt_frame_ctrl.sv -----
// ----------------------------------------------------------------------------
// ubt_frame_ctrl
// Frame state of the transmitter: applies one item per step and returns the
// line level, busy flag and send acceptance after the item.
// ----------------------------------------------------------------------------
`default_nettype none

module ubt_frame_ctrl (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        step,
  input  wire ubt_pkg::item_t              item,
  input  wire logic [ubt_pkg::PERIOD_W-1:0] bit_period,
  input  wire logic                        invert_line,
  output ubt_pkg::result_t                 res
);

  logic                          line_level_r, line_level_nxt;
  logic [ubt_pkg::DATA_BITS-1:0] shift_data_r, shift_data_nxt;
  ubt_pkg::phase_t               phase_r, phase_nxt;
  logic [ubt_pkg::TICK_W-1:0]    tick_count_r, tick_count_nxt;
  logic                          parity_value_r, parity_value_nxt;
  logic                          parity_on_r, parity_on_nxt;
  logic                          long_stop_r, long_stop_nxt;
  logic                          acc;

  logic [ubt_pkg::TICK_W-1:0]    len;
  logic [ubt_pkg::TICK_W-1:0]    tick_inc;
  ubt_pkg::phase_t               phase_inc;

  assign len = (phase_r == ubt_pkg::PH_STOP && long_stop_r) ?
               {bit_period, 1'b0} : {1'b0, bit_period};
  assign tick_inc  = tick_count_r + ubt_pkg::TICK_W'(1);
  assign phase_inc = (phase_r + ubt_pkg::phase_t'(1) == ubt_pkg::PH_PARITY && !parity_on_r) ?
                     ubt_pkg::PH_STOP : phase_r + ubt_pkg::phase_t'(1);

  always_comb begin
    line_level_nxt   = line_level_r;
    shift_data_nxt   = shift_data_r;
    phase_nxt        = phase_r;
    tick_count_nxt   = tick_count_r;
    parity_value_nxt = parity_value_r;
    parity_on_nxt    = parity_on_r;
    long_stop_nxt    = long_stop_r;
    acc              = 1'b0;
    if (item.kind == ubt_pkg::KIND_SEND) begin
      if (phase_r == ubt_pkg::PH_IDLE && bit_period != '0) begin
        shift_data_nxt   = item.data_byte[ubt_pkg::DATA_BITS-1:0];
        parity_value_nxt = ^item.data_byte[ubt_pkg::DATA_BITS-1:0];
        parity_on_nxt    = item.parity_enable;
        long_stop_nxt    = item.two_stop_bits;
        phase_nxt        = ubt_pkg::PH_START;
        tick_count_nxt   = '0;
        line_level_nxt   = 1'b0;
        acc              = 1'b1;
      end
    end else if (phase_r != ubt_pkg::PH_IDLE) begin
      tick_count_nxt = tick_inc;
      if (tick_inc >= len) begin
        tick_count_nxt = '0;
        if (phase_r >= ubt_pkg::PH_STOP) begin
          phase_nxt      = ubt_pkg::PH_IDLE;
          line_level_nxt = 1'b1;
        end else begin
          phase_nxt = phase_inc;
          if (phase_inc < ubt_pkg::PH_PARITY) begin
            line_level_nxt = shift_data_r[0];
            shift_data_nxt = shift_data_r >> 1;
          end else if (phase_inc == ubt_pkg::PH_PARITY) begin
            line_level_nxt = parity_value_r;
          end else begin
            line_level_nxt = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_level_r   <= 1'b1;
      shift_data_r   <= '0;
      phase_r        <= ubt_pkg::PH_IDLE;
      tick_count_r   <= '0;
      parity_value_r <= 1'b0;
      parity_on_r    <= 1'b0;
      long_stop_r    <= 1'b0;
    end else if (step) begin
      line_level_r   <= line_level_nxt;
      shift_data_r   <= shift_data_nxt;
      phase_r        <= phase_nxt;
      tick_count_r   <= tick_count_nxt;
      parity_value_r <= parity_value_nxt;
      parity_on_r    <= parity_on_nxt;
      long_stop_r    <= long_stop_nxt;
    end
  end

  assign res.tx_line  = line_level_nxt ^ invert_line;
  assign res.busy_res = (phase_nxt != ubt_pkg::PH_IDLE);
  assign res.accepted = acc;

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    step && acc |=> phase_r == ubt_pkg::PH_START && !line_level_r)
    else $error("accepted send did not enter start phase");

  a_accept_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    step && acc |-> phase_r == ubt_pkg::PH_IDLE && bit_period != '0)
    else $error("send accepted while busy or unconfigured");

  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r <= ubt_pkg::PH_STOP)
    else $error("frame phase out of range");

  a_idle_line_high: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == ubt_pkg::PH_IDLE |-> line_level_r && tick_count_r == '0)
    else $error("idle line not at idle level");

endmodule

`default_nettype wire

// ----- sv/uart_byte_transmitter.sv -----
// ----------------------------------------------------------------------------
// uart_byte_transmitter
// Serial byte transmitter driven by tick and send items, with a registered
// input stage and a registered result stage around the frame logic.
//
//   channel | direction | handshake        | payload
//   in_     | input     | in_valid/in_stall | kind, data_byte, parity_enable,
//           |           |                  | two_stop_bits
//   out_    | output    | out_valid/out_stall | tx_line, busy_res, accepted
//   cfg_    | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One item per cycle sustained while out_stall is low; each item passes
// through the input register and then the result register.
// Frame state updates once per item as it moves from the input register.
// Reset clears the valid flags, configuration and frame state at once; no clearing pass.
// A stalled result holds both stages; in_stall rises only when both are full.
// cfg_ready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

module uart_byte_transmitter (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          in_kind,
  input  wire logic [7:0]                    in_data_byte,
  input  wire logic                          in_parity_enable,
  input  wire logic                          in_two_stop_bits,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               out_tx_line,
  output logic                               out_busy_res,
  output logic                               out_accepted,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [ubt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ubt_pkg::PERIOD_W-1:0]  cfg_data
);

  logic                          s1_valid_r, s1_valid_nxt;
  ubt_pkg::item_t                s1_item_r;
  logic                          out_valid_r, out_valid_nxt;
  ubt_pkg::result_t              out_res_r;
  ubt_pkg::result_t              res;
  logic [ubt_pkg::PERIOD_W-1:0]  bit_period_r;
  logic                          invert_line_r;
  logic                          in_xfer;
  logic                          adv;

  assign adv      = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && out_valid_r && out_stall;
  assign in_xfer  = in_valid && !in_stall;

  assign s1_valid_nxt  = in_xfer ? 1'b1 : (adv ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = adv ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_item_r <= '{kind: in_kind, data_byte: in_data_byte,
                     parity_enable: in_parity_enable, two_stop_bits: in_two_stop_bits};
    end
    if (adv) begin
      out_res_r <= res;
    end
  end

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_period_r  <= '0;
      invert_line_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ubt_pkg::CFG_BIT_PERIOD:  bit_period_r  <= cfg_data;
        ubt_pkg::CFG_INVERT_LINE: invert_line_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  ubt_frame_ctrl u_frame (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (adv),
    .item        (s1_item_r),
    .bit_period  (bit_period_r),
    .invert_line (invert_line_r),
    .res         (res)
  );

  assign out_valid    = out_valid_r;
  assign out_tx_line  = out_res_r.tx_line;
  assign out_busy_res = out_res_r.busy_res;
  assign out_accepted = out_res_r.accepted;

endmodule

`default_nettype wire
